@@ rtl/olirf_pkg.sv @@
package olirf_pkg;

  // action codes of the input word
  localparam logic [2:0] ACT_INSERT     = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd4;
  localparam logic [2:0] ACT_FIND       = 3'd5;
  localparam logic [2:0] ACT_CLEAR      = 3'd6;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_FIND,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    POS_GIVEN,
    POS_END,
    POS_START
  } pos_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_PF_RD,
    S_PF_WR,
    S_FD_RD,
    S_FD_CMP
  } bk_state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [8:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] found_index;
    logic [8:0] entry_count;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t                op;
    pos_kind_t          pos_kind;
    logic [8:0]         position;
    logic signed [31:0] value;
  } cmd_t;

endpackage

@@ rtl/olirf_front.sv @@
module olirf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  olirf_pkg::in_word_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output olirf_pkg::cmd_t    cmd,
  output logic [1:0]         q_level
);
  import olirf_pkg::*;

  cmd_t       q_data_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] level_r;
  logic [1:0] level_nxt;
  cmd_t       dec;
  logic       push;
  logic       pop;

  // classify the action code
  always_comb begin
    dec.position = in_data.position;
    dec.value    = in_data.value;
    dec.pos_kind = POS_GIVEN;
    case (in_data.action)
      ACT_INSERT: begin
        dec.op = OP_INSERT;
      end
      ACT_PUSH_BACK: begin
        dec.op       = OP_INSERT;
        dec.pos_kind = POS_END;
      end
      ACT_PUSH_FRONT: begin
        dec.op       = OP_INSERT;
        dec.pos_kind = POS_START;
      end
      ACT_POP_BACK:  dec.op = OP_POP_BACK;
      ACT_POP_FRONT: dec.op = OP_POP_FRONT;
      ACT_FIND:      dec.op = OP_FIND;
      ACT_CLEAR:     dec.op = OP_CLEAR;
      default:       dec.op = OP_NOP;
    endcase
  end

  // two-word queue towards the back end
  assign in_stall  = (level_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && (level_r != 2'd0);
  assign cmd_valid = (level_r != 2'd0);
  assign cmd       = q_data_r[rd_ptr_r];
  assign q_level   = level_r;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 2'd1;
    end else if (pop && !push) begin
      level_nxt = level_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      level_r <= level_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data_r[wr_ptr_r] <= dec;
    end
  end

endmodule

@@ rtl/olirf_back.sv @@
module olirf_back #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  olirf_pkg::cmd_t     cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output olirf_pkg::out_word_t out_data
);
  import olirf_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (CW > 9) ? CW : 9;
  localparam int XB = WORD_BITS + 32;

  bk_state_t            state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_data_r, out_data_nxt;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [WORD_BITS-1:0] wdata;

  logic [XB-1:0]        val_ext;
  logic [WORD_BITS-1:0] cmd_word;
  logic [PW-1:0]        ins_pos;
  logic [CW-1:0]        idx_m1;
  logic [CW-1:0]        idx_p1;
  logic                 out_free;
  logic                 full;

  function automatic out_word_t mk_out(status_t s, logic [7:0] f, logic [CW-1:0] c);
    out_word_t o;
    o.status      = s;
    o.found_index = f;
    o.entry_count = 9'(c);
    return o;
  endfunction

  // operand preparation
  assign val_ext  = {{WORD_BITS{1'b0}}, cmd.value};
  assign cmd_word = val_ext[WORD_BITS-1:0];
  assign idx_m1   = idx_r - 1'b1;
  assign idx_p1   = idx_r + 1'b1;
  assign full     = (count_r == CW'(DEPTH));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (cmd.pos_kind)
      POS_GIVEN: ins_pos = PW'(cmd.position);
      POS_END:   ins_pos = PW'(count_r);
      default:   ins_pos = '0;
    endcase
  end

  // sequencer: one memory access per cycle
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    we            = 1'b0;
    waddr         = idx_r[AW-1:0];
    raddr         = idx_r[AW-1:0];
    wdata         = rdata_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop  = 1'b1;
          word_nxt = cmd_word;
          case (cmd.op)
            OP_INSERT: begin
              if (ins_pos > PW'(count_r)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = mk_out(ST_BADPOS, 8'd0, count_r);
              end else if (full) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = mk_out(ST_FULL, 8'd0, count_r);
              end else begin
                pos_nxt   = ins_pos[CW-1:0];
                idx_nxt   = count_r;
                state_nxt = (ins_pos == PW'(count_r)) ? S_PUT : S_SH_RD;
              end
            end
            OP_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_data_nxt = mk_out(ST_EMPTY, 8'd0, count_r);
              end else begin
                count_nxt    = count_r - 1'b1;
                out_data_nxt = mk_out(ST_OK, 8'd0, count_r - 1'b1);
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = mk_out(ST_EMPTY, 8'd0, count_r);
              end else if (count_r == CW'(1)) begin
                count_nxt     = '0;
                out_valid_nxt = 1'b1;
                out_data_nxt  = mk_out(ST_OK, 8'd0, '0);
              end else begin
                idx_nxt   = '0;
                state_nxt = S_PF_RD;
              end
            end
            OP_FIND: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = mk_out(ST_NOTFOUND, 8'd0, count_r);
              end else begin
                idx_nxt   = '0;
                state_nxt = S_FD_RD;
              end
            end
            OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = mk_out(ST_OK, 8'd0, '0);
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = mk_out(ST_OK, 8'd0, count_r);
            end
          endcase
        end
      end
      // shift up: read the entry below, then write it one place higher
      S_SH_RD: begin
        raddr     = idx_m1[AW-1:0];
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        we        = 1'b1;
        waddr     = idx_r[AW-1:0];
        idx_nxt   = idx_m1;
        state_nxt = (idx_m1 == pos_r) ? S_PUT : S_SH_RD;
      end
      S_PUT: begin
        we            = 1'b1;
        waddr         = pos_r[AW-1:0];
        wdata         = word_r;
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = mk_out(ST_OK, 8'd0, count_r + 1'b1);
        state_nxt     = S_IDLE;
      end
      // shift down for pop front
      S_PF_RD: begin
        raddr     = idx_p1[AW-1:0];
        state_nxt = S_PF_WR;
      end
      S_PF_WR: begin
        we      = 1'b1;
        waddr   = idx_r[AW-1:0];
        idx_nxt = idx_p1;
        if (idx_p1 + 1'b1 == count_r) begin
          count_nxt     = count_r - 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(ST_OK, 8'd0, count_r - 1'b1);
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_PF_RD;
        end
      end
      // linear search from the front
      S_FD_RD: begin
        raddr     = idx_r[AW-1:0];
        state_nxt = S_FD_CMP;
      end
      S_FD_CMP: begin
        if (rdata_r == word_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(ST_OK, 8'(idx_r), count_r);
          state_nxt     = S_IDLE;
        end else if (idx_p1 == count_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(ST_NOTFOUND, 8'd0, count_r);
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_FD_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
  end

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/ordered_list_insert_remove_find_top.sv @@
// channel | direction | handshake          | word
// in_     | input     | in_valid/in_stall   | action, position, value
// out_    | output    | out_valid/out_stall | status, found_index, entry_count
//
// Pop back, clear, unknown and refused actions finish in the back end's idle
// state; insert at position p first shifts entries p to count - 1 up one place
// (push back is p = count, no shift; push front is p = 0), pop front shifts the
// rest down one place, and find compares from index 0 to a match or the end.
// Each moved or compared entry takes a read state and then a write or compare
// state. The two-word queue adds a register in front of the back end.
// Synchronous active-low reset empties the list and the queue.
// A stalled result holds the back end; the front keeps taking words until full.
module ordered_list_insert_remove_find_top #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  olirf_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output olirf_pkg::out_word_t out_data
);
  import olirf_pkg::*;

  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_pop;
  logic [1:0] q_level;

  // front end: classify and queue
  olirf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .q_level   (q_level)
  );

  // back end: list store and sequencer
  olirf_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level != 2'd3)
    else $error("queue level out of range");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == 9'(DEPTH))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.entry_count == 9'd0)
    else $error("empty status with entries present");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.found_index == 8'd0)
    else $error("found index set on failed action");
`endif

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import olirf_pkg::*;

  localparam int DEPTH = 256;
  // action code with no meaning: no change, status ok
  localparam logic [2:0] ACT_NONE = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  ordered_list_insert_remove_find_top #(.DEPTH(DEPTH), .WORD_BITS(32)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predicted list contents
  logic [31:0] list_model [DEPTH];
  int          list_len;

  in_word_t  pending_words [$];
  out_word_t expected_results [$];
  int        errors;
  int        accepted_in;
  int        accepted_out;
  int        status_seen [5];
  bit        quiet_tail;
  bit        sender_hold;
  bit        hold_req;
  bit        hold_done;
  int        long_hold;

  // list behaviour for one accepted word
  function automatic out_word_t apply_action(in_word_t w);
    out_word_t r;
    int        p;
    bit        ins;
    r.status = ST_OK;
    r.found_index = '0;
    ins = 1'b0;
    p = 0;
    case (w.action)
      ACT_INSERT: begin
        ins = 1'b1;
        p = int'(w.position);
      end
      ACT_PUSH_BACK: begin
        ins = 1'b1;
        p = list_len;
      end
      ACT_PUSH_FRONT: begin
        ins = 1'b1;
        p = 0;
      end
      ACT_POP_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      ACT_POP_FRONT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          for (int i = 0; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
          list_len--;
        end
      end
      ACT_FIND: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < list_len; i++) begin
          if (list_model[i] == w.value) begin
            r.status = ST_OK;
            r.found_index = 8'(i);
            break;
          end
        end
      end
      ACT_CLEAR: list_len = 0;
      default: ;
    endcase
    if (ins) begin
      if (p > list_len) r.status = ST_BADPOS;
      else if (list_len >= DEPTH) r.status = ST_FULL;
      else begin
        for (int i = list_len; i > p; i--) list_model[i] = list_model[i-1];
        list_model[p] = w.value;
        list_len++;
      end
    end
    r.entry_count = 9'(list_len);
    return r;
  endfunction

  function automatic in_word_t make_word(logic [2:0] a, int pos, logic [31:0] v);
    in_word_t w;
    w.action = a;
    w.position = 9'(pos);
    w.value = v;
    return w;
  endfunction

  // values mostly drawn from small pools so that finds hit often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 7));
      1: return $urandom;
      2: return {1'b1, 31'($urandom_range(0, 3))};
      default: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'h3fff_fffc | 30'($urandom_range(0, 3))};
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: offers queued words at the falling edge
  int send_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() > 0 && !sender_hold) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
        if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  int stall_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      long_hold <= 0;
      hold_done <= 1'b0;
    end else if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold <= long_hold - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      long_hold <= 399;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // input acceptance and result checking at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_action(in_data));
        accepted_in++;
      end
      if (out_valid && !out_stall) begin
        accepted_out++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %p", out_data);
          errors++;
        end else begin
          out_word_t e;
          e = expected_results.pop_front();
          if (out_data.status != e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data.status);
            errors++;
          end
          if (out_data.found_index != e.found_index) begin
            $error("found_index: expected %0d, got %0d", e.found_index,
                   out_data.found_index);
            errors++;
          end
          if (out_data.entry_count != e.entry_count) begin
            $error("entry_count: expected %0d, got %0d", e.entry_count,
                   out_data.entry_count);
            errors++;
          end
          if (int'(e.status) < 5) status_seen[int'(e.status)]++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    int lvl;
    int n;
    errors = 0;
    accepted_in = 0;
    accepted_out = 0;
    quiet_tail = 1'b0;
    sender_hold = 1'b0;
    hold_req = 1'b0;
    list_len = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list cases, extremes, bad position, full list
    pending_words.push_back(make_word(ACT_POP_BACK, 0, 0));
    pending_words.push_back(make_word(ACT_POP_FRONT, 0, 0));
    pending_words.push_back(make_word(ACT_FIND, 0, 0));
    pending_words.push_back(make_word(ACT_INSERT, 1, 5));
    pending_words.push_back(make_word(ACT_INSERT, 0, 32'h8000_0000));
    pending_words.push_back(make_word(ACT_PUSH_BACK, 0, 32'h7fff_ffff));
    pending_words.push_back(make_word(ACT_PUSH_FRONT, 0, 32'hffff_ffff));
    pending_words.push_back(make_word(ACT_INSERT, 3, 0));
    pending_words.push_back(make_word(ACT_INSERT, 1, 32'h5555_aaaa));
    pending_words.push_back(make_word(ACT_INSERT, 511, 1));
    pending_words.push_back(make_word(ACT_FIND, 0, 32'h7fff_ffff));
    pending_words.push_back(make_word(ACT_FIND, 0, 32'h1234_5678));
    pending_words.push_back(make_word(ACT_NONE, 0, 0));
    pending_words.push_back(make_word(ACT_POP_FRONT, 0, 0));
    pending_words.push_back(make_word(ACT_POP_BACK, 0, 0));
    pending_words.push_back(make_word(ACT_CLEAR, 0, 0));
    for (int i = 0; i < DEPTH; i++)
      pending_words.push_back(make_word(ACT_PUSH_BACK, 0, 32'(i)));
    pending_words.push_back(make_word(ACT_PUSH_FRONT, 0, 1));
    pending_words.push_back(make_word(ACT_INSERT, 256, 1));
    pending_words.push_back(make_word(ACT_INSERT, 257, 1));
    pending_words.push_back(make_word(ACT_FIND, 0, 255));
    pending_words.push_back(make_word(ACT_FIND, 0, 254));
    pending_words.push_back(make_word(ACT_CLEAR, 0, 0));
    wait_drained();

    // sender pause while words queue up, then a long receiver hold-off
    sender_hold = 1'b1;
    repeat (20) @(posedge clk);
    for (int i = 0; i < 40; i++)
      pending_words.push_back(make_word(ACT_PUSH_BACK, 0, pick_value()));
    @(negedge clk);
    hold_req = 1'b1;
    sender_hold = 1'b0;
    wait_drained();

    // random: mostly small lists, one phase grown near full
    n = 0;
    while (n < 800) begin
      if (n > 650 && !quiet_tail) begin
        wait_drained();
        quiet_tail = 1'b1;
      end
      lvl = (n == 400) ? DEPTH : 12;
      for (int k = 0; k < 50; k++) begin
        int a;
        a = $urandom_range(0, 99);
        if (a < 20) pending_words.push_back(make_word(ACT_INSERT,
            $urandom_range(0, 7) == 0 ? $urandom_range(0, 511)
                                      : $urandom_range(0, lvl / 4 + 2), pick_value()));
        else if (a < 35) pending_words.push_back(make_word(ACT_PUSH_BACK,
            $urandom_range(0, 511), pick_value()));
        else if (a < 48) pending_words.push_back(make_word(ACT_PUSH_FRONT,
            $urandom_range(0, 511), pick_value()));
        else if (a < 58) pending_words.push_back(make_word(ACT_POP_BACK,
            $urandom_range(0, 511), $urandom));
        else if (a < 68) pending_words.push_back(make_word(ACT_POP_FRONT,
            $urandom_range(0, 511), $urandom));
        else if (a < 93) pending_words.push_back(make_word(ACT_FIND,
            $urandom_range(0, 511), pick_value()));
        else if (a < 96) pending_words.push_back(make_word(ACT_NONE,
            $urandom_range(0, 511), $urandom));
        else pending_words.push_back(make_word(lvl == DEPTH ? ACT_PUSH_BACK : ACT_CLEAR,
            $urandom_range(0, 511), $urandom));
        if (lvl == DEPTH && k == 0)
          for (int j = 0; j < DEPTH; j++)
            pending_words.push_back(make_word(ACT_PUSH_FRONT, 0, pick_value()));
      end
      n += 50;
      while (pending_words.size() > 20) @(posedge clk);
    end
    wait_drained();
    repeat (2000) @(posedge clk);

    $display("covered %0d words in, %0d results out; ok %0d, bad position %0d,",
             accepted_in, accepted_out, status_seen[0], status_seen[1]);
    $display("empty %0d, full %0d, not found %0d", status_seen[2], status_seen[3],
             status_seen[4]);
    if (errors == 0 && expected_results.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // timeout
  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/olirf_pkg.sv
rtl/olirf_front.sv
rtl/olirf_back.sv
rtl/ordered_list_insert_remove_find_top.sv
test/testbench.sv
